[src/ssl_pkg.sv]
// Package for the sorted shift list table: record, cell control and action types.
// Used by ssl_cell and sorted_shift_list_table; depends on nothing.
package ssl_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int KEY_W     = 32;
  localparam int PAY_W     = 64;
  localparam int ACT_W     = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_INS_TAIL = 3'd0,
    ACT_INS_HEAD = 3'd1,
    ACT_INS_ORD  = 3'd2,
    ACT_RM_TAIL  = 3'd3,
    ACT_RM_HEAD  = 3'd4,
    ACT_RM_KEY   = 3'd5,
    ACT_RD_POS   = 3'd6,
    ACT_RD_KEY   = 3'd7
  } act_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic        [PAY_W-1:0] payload;
  } rec_t;

  // cell move: hold, load the incoming record, take from the lower or upper neighbor
  typedef enum logic [1:0] {
    MV_HOLD  = 2'd0,
    MV_NEW   = 2'd1,
    MV_LEFT  = 2'd2,
    MV_RIGHT = 2'd3
  } mv_t;

  typedef struct packed {
    logic cmp_en;
    logic car_load;
    logic sel;
    mv_t  mv;
  } cell_ctl_t;

  typedef struct packed {
    logic less;
    logic eq;
  } flag_t;

endpackage

[src/ssl_cell.sv]
// One list cell: holds a record, compares it with the command key and
// passes records and the read carry to its neighbors. Depends on ssl_pkg.
module ssl_cell (
  input  logic              clk,
  input  ssl_pkg::cell_ctl_t ctl,
  input  ssl_pkg::rec_t     cmd_rec,
  input  ssl_pkg::rec_t     left_rec,
  input  ssl_pkg::rec_t     right_rec,
  input  ssl_pkg::rec_t     right_carry,
  output ssl_pkg::rec_t     rec,
  output ssl_pkg::rec_t     carry,
  output ssl_pkg::flag_t    flag
);
  import ssl_pkg::*;

  rec_t  rec_r, rec_nxt;
  rec_t  carry_r, carry_nxt;
  flag_t flag_r, flag_nxt;

  always_comb begin
    case (ctl.mv)
      MV_NEW:   rec_nxt = cmd_rec;
      MV_LEFT:  rec_nxt = left_rec;
      MV_RIGHT: rec_nxt = right_rec;
      default:  rec_nxt = rec_r;
    endcase
  end

  always_comb begin
    flag_nxt = flag_r;
    if (ctl.cmp_en) begin
      flag_nxt.less = rec_r.key < cmd_rec.key;
      flag_nxt.eq   = rec_r.key == cmd_rec.key;
    end
  end

  // on load take the own record if selected, else zero; otherwise shift the carry toward cell 0
  assign carry_nxt = ctl.car_load ? (ctl.sel ? rec_r : '0) : right_carry;

  always_ff @(posedge clk) begin
    rec_r   <= rec_nxt;
    flag_r  <= flag_nxt;
    carry_r <= carry_nxt;
  end

  assign rec   = rec_r;
  assign carry = carry_r;
  assign flag  = flag_r;

endmodule

[src/sorted_shift_list_table.sv]
// Top level of the sorted shift list table: command sequencer, chain of
// ssl_cell instances and output register. Depends on ssl_pkg and ssl_cell.
//
//  channel | dir | handshake           | word
//  --------+-----+---------------------+-----------------------------------------
//  in_     | in  | in_tvalid/in_tready | action, key, payload, position
//  out_    | out | out_tvalid/out_tready | ok, out_key, out_payload, count, full, empty
//
// Steps: an insert or remove passes from accept to result through compare,
// update and output load; a read adds a scan after the update, in which the read
// carry walks down the cell chain one cell per cycle toward cell 0.
// One item is in work at a time; in_tready is high only while the sequencer idles.
// A result waiting in the output register does not block the next accept;
// a finished item holds in the done state until the output register frees up.
// rst_n is synchronous, active low, and clears count and control only.
module sorted_shift_list_table #(
  parameter int DEPTH = ssl_pkg::DEPTH_DEF,
  localparam int CNT_W = $clog2(DEPTH + 1),
  localparam int IN_W  = ssl_pkg::ACT_W + ssl_pkg::KEY_W + ssl_pkg::PAY_W + CNT_W,
  localparam int OUT_W = 1 + ssl_pkg::KEY_W + ssl_pkg::PAY_W + CNT_W + 2,
  localparam int IN_TD_W  = ((IN_W + 7) / 8) * 8,
  localparam int OUT_TD_W = ((OUT_W + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // action, key, payload, position (lowest bit up), zero padded
  input  logic [IN_TD_W-1:0]  in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // ok, out_key, out_payload, count, full_res, empty_res (lowest bit up), zero padded
  output logic [OUT_TD_W-1:0] out_tdata
);
  import ssl_pkg::*;

  localparam int SC_W = $clog2(DEPTH);
  localparam int LG   = $clog2(DEPTH);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CMP  = 5'b00010,
    ST_EXEC = 5'b00100,
    ST_SCAN = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  // mark every position at or above the lowest set bit
  function automatic logic [DEPTH-1:0] pfx_or(input logic [DEPTH-1:0] v);
    logic [DEPTH-1:0] t;
    t = v;
    for (int s = 0; s < LG; s++) begin
      t = t | (t << (1 << s));
    end
    return t;
  endfunction

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SC_W-1:0]   scan_r, scan_nxt;
  act_t              act_r, act_nxt;
  rec_t              cmd_r, cmd_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic              ok_r, ok_nxt;
  rec_t              acc_r, acc_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_ok_r, out_ok_nxt;
  rec_t              out_rec_r, out_rec_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic              out_full_r, out_full_nxt;
  logic              out_empty_r, out_empty_nxt;

  rec_t              recs   [DEPTH];
  rec_t              carries[DEPTH];
  flag_t             flags  [DEPTH];
  cell_ctl_t         ctls   [DEPTH];

  logic [DEPTH-1:0]  valid_v, less_v, eq_v, sel_pos_v;
  logic [DEPTH-1:0]  ge_c, first_c, sel_c, match_c;
  logic              ok_c, ins_c, rm_c, rd_c;
  logic              full_now, empty_now, pos_ok, out_free;
  logic [CNT_W-1:0]  cnt_c;

  assign in_tready = (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_tready;
  assign full_now  = (count_r == CNT_W'(DEPTH));
  assign empty_now = (count_r == '0);
  assign pos_ok    = (pos_r != '0) && (pos_r <= count_r);

  // ---- cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign valid_v[i]   = CNT_W'(i) < count_r;
    assign less_v[i]    = flags[i].less;
    assign eq_v[i]      = flags[i].eq;
    assign sel_pos_v[i] = (pos_r == CNT_W'(i + 1));

    always_comb begin
      ctls[i].cmp_en   = (state_r == ST_CMP);
      ctls[i].car_load = (state_r == ST_EXEC);
      ctls[i].sel      = (state_r == ST_EXEC) && sel_c[i];
      ctls[i].mv       = MV_HOLD;
      if (state_r == ST_EXEC && ok_c) begin
        if (ins_c && first_c[i]) begin
          ctls[i].mv = MV_NEW;
        end else if (ins_c && ge_c[i]) begin
          ctls[i].mv = MV_LEFT;
        end else if (rm_c && ge_c[i]) begin
          ctls[i].mv = MV_RIGHT;
        end
      end
    end

    ssl_cell u_cell (
      .clk         (clk),
      .ctl         (ctls[i]),
      .cmd_rec     (cmd_r),
      .left_rec    (recs[(i == 0) ? 0 : i - 1]),
      .right_rec   (recs[(i == DEPTH - 1) ? DEPTH - 1 : i + 1]),
      .right_carry ((i == DEPTH - 1) ? rec_t'('0) : carries[(i == DEPTH - 1) ? i : i + 1]),
      .rec         (recs[i]),
      .carry       (carries[i]),
      .flag        (flags[i])
    );
  end

  // ---- decode the latched command against the registered cell flags
  always_comb begin
    ge_c    = '0;
    sel_c   = '0;
    ok_c    = 1'b0;
    ins_c   = 1'b0;
    rm_c    = 1'b0;
    rd_c    = 1'b0;
    match_c = valid_v & eq_v;
    unique case (act_r)
      ACT_INS_TAIL: begin
        ins_c = 1'b1;
        ok_c  = !full_now;
        ge_c  = ~valid_v;
      end
      ACT_INS_HEAD: begin
        ins_c = 1'b1;
        ok_c  = !full_now;
        ge_c  = '1;
      end
      ACT_INS_ORD: begin
        ins_c = 1'b1;
        ok_c  = !full_now;
        ge_c  = pfx_or(valid_v & ~less_v) | ~valid_v;
      end
      ACT_RM_TAIL: begin
        rm_c = 1'b1;
        ok_c = !empty_now;
      end
      ACT_RM_HEAD: begin
        rm_c = 1'b1;
        ok_c = !empty_now;
        ge_c = '1;
      end
      ACT_RM_KEY: begin
        rm_c = 1'b1;
        ok_c = |match_c;
        ge_c = pfx_or(match_c);
      end
      ACT_RD_POS: begin
        rd_c  = 1'b1;
        ok_c  = pos_ok;
        sel_c = sel_pos_v & {DEPTH{pos_ok}};
      end
      ACT_RD_KEY: begin
        rd_c  = 1'b1;
        ok_c  = |match_c;
        ge_c  = pfx_or(match_c);
        sel_c = ge_c & ~(ge_c << 1);
      end
      default: begin
        ok_c = 1'b0;
      end
    endcase
    first_c = ge_c & ~(ge_c << 1);
    cnt_c   = count_r;
    if (ok_c && ins_c) begin
      cnt_c = count_r + CNT_W'(1);
    end else if (ok_c && rm_c) begin
      cnt_c = count_r - CNT_W'(1);
    end
  end

  // ---- sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    act_nxt       = act_r;
    cmd_nxt       = cmd_r;
    pos_nxt       = pos_r;
    ok_nxt        = ok_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_ok_nxt    = out_ok_r;
    out_rec_nxt   = out_rec_r;
    out_cnt_nxt   = out_cnt_r;
    out_full_nxt  = out_full_r;
    out_empty_nxt = out_empty_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          // latch the word: action, key, payload, position
          act_nxt         = act_t'(in_tdata[ACT_W-1:0]);
          cmd_nxt.key     = in_tdata[ACT_W +: KEY_W];
          cmd_nxt.payload = in_tdata[ACT_W + KEY_W +: PAY_W];
          pos_nxt         = in_tdata[ACT_W + KEY_W + PAY_W +: CNT_W];
          state_nxt       = ST_CMP;
        end
      end
      ST_CMP: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        ok_nxt    = ok_c;
        count_nxt = cnt_c;
        acc_nxt   = '0;
        scan_nxt  = '0;
        state_nxt = rd_c ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        // unselected cells carry zero, so OR in whatever reaches cell 0
        acc_nxt  = acc_r | carries[0];
        scan_nxt = scan_r + SC_W'(1);
        if (scan_r == SC_W'(DEPTH - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = ok_r;
          out_rec_nxt   = acc_r;
          out_cnt_nxt   = count_r;
          out_full_nxt  = full_now;
          out_empty_nxt = empty_now;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r      <= scan_nxt;
    act_r       <= act_nxt;
    cmd_r       <= cmd_nxt;
    pos_r       <= pos_nxt;
    ok_r        <= ok_nxt;
    acc_r       <= acc_nxt;
    out_ok_r    <= out_ok_nxt;
    out_rec_r   <= out_rec_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_full_r  <= out_full_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TD_W'({out_empty_r, out_full_r, out_cnt_r,
                                 out_rec_r.payload, out_rec_r.key, out_ok_r});

endmodule

[src/ssl_check.sv]
// Port-level checker for sorted_shift_list_table and the bind that attaches it.
// Depends only on the top level's port list and its OUT_TD_W parameter.
module ssl_check #(
  parameter int OUT_TD_W = 104
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OUT_TD_W-1:0] out_tdata
);

  logic       in_acc, out_acc;
  logic [1:0] pend_r, pend_nxt;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 2'd1;
    end else if (!in_acc && out_acc && pend_r != 2'd0) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // one item in work: no accept right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input accepted while an item is in work");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // no result without an accepted item
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != 2'd0)
    else $error("result without an accepted item");

  // at most one item in work plus one waiting result
  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> pend_r <= 2'd1)
    else $error("more items in flight than the block can hold");

endmodule

bind sorted_shift_list_table ssl_check #(
  .OUT_TD_W (OUT_TD_W)
) u_ssl_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
